// ===== sv/packet_filter_rate_limiter_unit_assert.svh =====
// Assertion macros shared by the rate limiter RTL.
// No dependencies.
`ifndef PACKET_FILTER_RATE_LIMITER_UNIT_ASSERT_SVH
`define PACKET_FILTER_RATE_LIMITER_UNIT_ASSERT_SVH
`define PFRL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PFRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/pfrl_pkg.sv =====
// Shared types and constants for the packet filter rate limiter.
// No dependencies.
package pfrl_pkg;
   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_DENY   = 2'd1;
   localparam logic [1:0] ACT_RULE   = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [2:0] CAUSE_OK     = 3'd0;
   localparam logic [2:0] CAUSE_NONIP  = 3'd1;
   localparam logic [2:0] CAUSE_TRUNC  = 3'd2;
   localparam logic [2:0] CAUSE_DENY   = 3'd3;
   localparam logic [2:0] CAUSE_PORT   = 3'd4;
   localparam logic [2:0] CAUSE_RATE   = 3'd5;
   localparam logic [2:0] CAUSE_WRITE  = 3'd6;

   localparam logic [0:0] CSR_TOKEN_PERIOD = 1'd0;
   localparam logic [0:0] CSR_BUCKET_SIZE  = 1'd1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] frame_length;
      logic [15:0] ethertype;
      logic [3:0]  header_words;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] dest_port;
      logic [63:0] now_ns;
      logic [5:0]  slot;
      logic        enable;
      logic        permit;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [2:0]  cause;
      logic [15:0] tokens_left;
      logic [63:0] pass_total;
      logic [63:0] drop_total;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [31:0] data;
   } csr_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage

// ===== sv/pfrl_if.sv =====
// Valid/ready channel interfaces for the rate limiter.
// Depends on pfrl_pkg.
interface pfrl_req_if import pfrl_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pfrl_rsp_if import pfrl_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pfrl_csr_if import pfrl_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/packet_filter_rate_limiter_unit.sv =====
// Packet filter with per-source token bucket rate limiter, top level.
// Depends on pfrl_pkg, pfrl_if and pfrl_div.
// Usage:
//   req: one item per transfer, a packet header (action 0), a table slot
//   write (deny or port rule) or a no-op. rsp: one result per item, with verdict, cause,
//   tokens left and the pass and drop totals. csr: register index 0 sets
//   the token period in ns, index 1 sets bucket_size; write only while idle.
//   A table write goes from the req transfer through S_DONE to S_OUT,
//   where its result is valid. A packet walks the deny table (one slot per
//   cycle), then the port rule table (TCP or UDP with a nonzero port only)
//   and the rate table, each after a step that fetches slot 0; a tracked
//   source adds a divide. The next req transfer comes in S_IDLE after the
//   rsp transfer at the earliest.
//   req is not ready while an item is at work or a result waits.
//   Reset clears all valid bits and the totals at once and loads the
//   register defaults; tables need no clearing pass.
//   A stalled rsp holds its result; the block takes no new item until the
//   result is transferred.
`include "packet_filter_rate_limiter_unit_assert.svh"
module packet_filter_rate_limiter_unit import pfrl_pkg::*; #(
   parameter int DENY_SLOTS = 64,
   parameter int PORT_SLOTS = 64,
   parameter int RATE_SLOTS = 64
) (
   input logic clock,
   input logic reset,
   pfrl_req_if.sink   req,
   pfrl_rsp_if.source rsp,
   pfrl_csr_if.sink   csr
);
   localparam int DW = (DENY_SLOTS > 1) ? $clog2(DENY_SLOTS) : 1;
   localparam int PW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int RW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DENY, S_RULE, S_RATE, S_DIV_GO, S_DIV_WAIT,
      S_UPDATE, S_NEW, S_DONE, S_OUT
   } state_type;

   logic [31:0] deny_addr_mem [DENY_SLOTS];
   logic [DENY_SLOTS-1:0] deny_act_ff;
   logic [15:0] rule_port_mem [PORT_SLOTS];
   logic [7:0]  rule_proto_mem [PORT_SLOTS];
   logic [PORT_SLOTS-1:0] rule_allow_ff;
   logic [PORT_SLOTS-1:0] rule_valid_ff;
   logic [31:0] bk_src_mem [RATE_SLOTS];
   logic [15:0] bk_tok_mem [RATE_SLOTS];
   logic [63:0] bk_time_mem [RATE_SLOTS];
   logic [RATE_SLOTS-1:0] bk_valid_ff;

   state_type   state_ff;
   req_type     item_ff;
   rsp_type     out_ff;
   logic [31:0] npt_ff;
   logic [15:0] bsize_ff;
   logic [63:0] pass_ff, drop_ff;
   logic [12:0] idx_ff;
   logic        free_found_ff;
   logic [RW-1:0] free_ff, hit_ff;
   logic        verdict_ff;
   logic [2:0]  cause_ff;
   logic [15:0] left_ff;
   logic        run_limit_ff;

   logic [31:0] rd_addr_ff;
   logic [15:0] rd_port_ff;
   logic [7:0]  rd_proto_ff;
   logic [31:0] rd_src_ff;
   logic [15:0] rd_tok_ff;
   logic [63:0] rd_time_ff;

   logic        div_start;
   div_ctl_type div_ctl;
   logic [63:0] div_q;
   logic [63:0] elapsed;
   logic [17:0] l4_need;
   logic [16:0] tok_sum;
   logic [15:0] tok_cap;

   assign elapsed = item_ff.now_ns - rd_time_ff;

   pfrl_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(elapsed), .divisor(npt_ff), .ctl(div_ctl), .quotient(div_q)
   );

   assign div_start = (state_ff == S_DIV_GO);
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = out_ff;

   always_comb begin
      l4_need = 18'd14 + {12'd0, item_ff.header_words, 2'b00}
         + ((item_ff.protocol == PROTO_TCP) ? 18'd20 : 18'd8);
      tok_sum = {1'b0, rd_tok_ff} + {1'b0, div_q[15:0]};
      if (div_q >= 64'd65536 || tok_sum > {1'b0, bsize_ff}) tok_cap = bsize_ff;
      else tok_cap = tok_sum[15:0];
   end

   // table reads, registered, one address per cycle
   always_ff @(posedge clock) begin
      rd_addr_ff  <= deny_addr_mem[idx_ff[DW-1:0]];
      rd_port_ff  <= rule_port_mem[idx_ff[PW-1:0]];
      rd_proto_ff <= rule_proto_mem[idx_ff[PW-1:0]];
      rd_src_ff   <= bk_src_mem[idx_ff[RW-1:0]];
      rd_tok_ff   <= bk_tok_mem[(state_ff == S_RATE) ? idx_ff[RW-1:0] - RW'(1) : hit_ff];
      rd_time_ff  <= bk_time_mem[(state_ff == S_RATE) ? idx_ff[RW-1:0] - RW'(1) : hit_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid) begin
         if (req.data.action == ACT_DENY && {7'd0, req.data.slot} < 13'(DENY_SLOTS))
            deny_addr_mem[DW'(req.data.slot)] <= req.data.src_ip;
         if (req.data.action == ACT_RULE && {7'd0, req.data.slot} < 13'(PORT_SLOTS)) begin
            rule_port_mem[PW'(req.data.slot)] <= req.data.dest_port;
            rule_proto_mem[PW'(req.data.slot)] <= req.data.protocol;
         end
      end
      if (state_ff == S_UPDATE && div_q != 64'd0)
         bk_time_mem[hit_ff] <= item_ff.now_ns;
      if (state_ff == S_UPDATE)
         bk_tok_mem[hit_ff] <= (tok_cap != 16'd0) ? tok_cap - 16'd1 : 16'd0;
      if (state_ff == S_NEW && free_found_ff) begin
         bk_src_mem[free_ff] <= item_ff.src_ip;
         bk_tok_mem[free_ff] <= (bsize_ff != 16'd0) ? bsize_ff - 16'd1 : 16'd0;
         bk_time_mem[free_ff] <= item_ff.now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         npt_ff <= 32'd1000000;
         bsize_ff <= 16'd5000;
         pass_ff <= '0;
         drop_ff <= '0;
         deny_act_ff <= '0;
         rule_valid_ff <= '0;
         rule_allow_ff <= '0;
         bk_valid_ff <= '0;
         idx_ff <= '0;
         free_found_ff <= 1'b0;
         free_ff <= '0;
         hit_ff <= '0;
         verdict_ff <= 1'b0;
         cause_ff <= CAUSE_OK;
         left_ff <= '0;
         run_limit_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.data.index)
               CSR_TOKEN_PERIOD: npt_ff <= csr.data.data;
               CSR_BUCKET_SIZE:  bsize_ff <= csr.data.data[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               idx_ff <= '0;
               if (req.valid) begin
                  item_ff <= req.data;
                  verdict_ff <= 1'b0;
                  left_ff <= '0;
                  free_found_ff <= 1'b0;
                  if (req.data.action == ACT_DENY && {7'd0, req.data.slot} < 13'(DENY_SLOTS))
                     deny_act_ff[DW'(req.data.slot)] <= req.data.enable;
                  if (req.data.action == ACT_RULE && {7'd0, req.data.slot} < 13'(PORT_SLOTS)) begin
                     rule_valid_ff[PW'(req.data.slot)] <= req.data.enable;
                     rule_allow_ff[PW'(req.data.slot)] <= req.data.permit;
                  end
                  if (req.data.action != ACT_PACKET) begin
                     cause_ff <= CAUSE_WRITE;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               cause_ff <= CAUSE_OK;
               run_limit_ff <= 1'b0;
               if (item_ff.frame_length < 16'd14) begin
                  verdict_ff <= 1'b1; cause_ff <= CAUSE_TRUNC; state_ff <= S_DONE;
               end else if (item_ff.ethertype != ETHERTYPE_IPV4) begin
                  cause_ff <= CAUSE_NONIP; state_ff <= S_DONE;
               end else if (item_ff.frame_length < 16'd34) begin
                  verdict_ff <= 1'b1; cause_ff <= CAUSE_TRUNC; state_ff <= S_DONE;
               end else begin
                  idx_ff <= 13'd1;
                  state_ff <= S_DENY;
               end
            end
            S_DENY: begin
               // rd_addr_ff holds slot idx_ff-1
               if (deny_act_ff[idx_ff[DW-1:0] - DW'(1)] &&
                   (rd_addr_ff == item_ff.src_ip || rd_addr_ff == item_ff.dst_ip)) begin
                  verdict_ff <= 1'b1; cause_ff <= CAUSE_DENY; state_ff <= S_DONE;
               end else if (idx_ff == 13'(DENY_SLOTS)) begin
                  idx_ff <= 13'd0;
                  if ((item_ff.protocol == PROTO_TCP || item_ff.protocol == PROTO_UDP) &&
                      {2'b00, item_ff.frame_length} < l4_need) begin
                     verdict_ff <= 1'b1; cause_ff <= CAUSE_TRUNC; state_ff <= S_DONE;
                  end else if ((item_ff.protocol == PROTO_TCP ||
                                item_ff.protocol == PROTO_UDP) &&
                               item_ff.dest_port != 16'd0) begin
                     state_ff <= S_RULE;
                  end else begin
                     state_ff <= S_RATE;
                  end
               end else begin
                  idx_ff <= idx_ff + 13'd1;
               end
            end
            S_RULE: begin
               // idx_ff 0: fetch slot 0
               if (idx_ff == 13'd0) begin
                  idx_ff <= 13'd1;
               end else if (rule_valid_ff[idx_ff[PW-1:0] - PW'(1)] &&
                            rd_port_ff == item_ff.dest_port) begin
                  if ((rd_proto_ff == 8'd0 || rd_proto_ff == item_ff.protocol) &&
                      !rule_allow_ff[idx_ff[PW-1:0] - PW'(1)]) begin
                     verdict_ff <= 1'b1; cause_ff <= CAUSE_PORT; state_ff <= S_DONE;
                  end else begin
                     idx_ff <= 13'd0; state_ff <= S_RATE;
                  end
               end else if (idx_ff == 13'(PORT_SLOTS)) begin
                  idx_ff <= 13'd0; state_ff <= S_RATE;
               end else begin
                  idx_ff <= idx_ff + 13'd1;
               end
            end
            S_RATE: begin
               run_limit_ff <= 1'b1;
               if (idx_ff == 13'd0) begin
                  idx_ff <= 13'd1;
               end else if (bk_valid_ff[idx_ff[RW-1:0] - RW'(1)] &&
                            rd_src_ff == item_ff.src_ip) begin
                  hit_ff <= idx_ff[RW-1:0] - RW'(1);
                  state_ff <= S_DIV_GO;
               end else begin
                  if (!bk_valid_ff[idx_ff[RW-1:0] - RW'(1)] && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff <= idx_ff[RW-1:0] - RW'(1);
                  end
                  if (idx_ff == 13'(RATE_SLOTS)) state_ff <= S_NEW;
                  else idx_ff <= idx_ff + 13'd1;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: if (!div_ctl.busy && !div_ctl.start) state_ff <= S_UPDATE;
            S_UPDATE: begin
               if (tok_cap != 16'd0) begin
                  left_ff <= tok_cap - 16'd1;
               end else begin
                  verdict_ff <= 1'b1; cause_ff <= CAUSE_RATE;
               end
               state_ff <= S_DONE;
            end
            S_NEW: begin
               if (free_found_ff) begin
                  bk_valid_ff[free_ff] <= 1'b1;
                  left_ff <= (bsize_ff != 16'd0) ? bsize_ff - 16'd1 : 16'd0;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (item_ff.action == ACT_PACKET) begin
                  if (verdict_ff) drop_ff <= drop_ff + 64'd1;
                  else pass_ff <= pass_ff + 64'd1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         out_ff.verdict <= verdict_ff;
         out_ff.cause <= cause_ff;
         out_ff.tokens_left <= left_ff;
         out_ff.pass_total <= (item_ff.action == ACT_PACKET && !verdict_ff) ?
            pass_ff + 64'd1 : pass_ff;
         out_ff.drop_total <= (item_ff.action == ACT_PACKET && verdict_ff) ?
            drop_ff + 64'd1 : drop_ff;
      end
   end

   `PFRL_ASSERT_NEXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `PFRL_ASSERT_IMPL(a_rate_pass, clock, reset,
      rsp.valid && out_ff.cause == CAUSE_RATE, out_ff.verdict && run_limit_ff)
   `PFRL_ASSERT_IMPL(a_write_pass, clock, reset,
      rsp.valid && out_ff.cause == CAUSE_WRITE, !out_ff.verdict)
endmodule

// ===== sv/pfrl_div.sv =====
// Restoring 64/32 divider, one quotient bit per cycle.
// Depends on pfrl_pkg.
`include "packet_filter_rate_limiter_unit_assert.svh"
module pfrl_div import pfrl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output div_ctl_type ctl,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[31:0], quo_ff[63]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = (divisor == 32'd0) ? 32'd1 : divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign quotient = quo_ff;

   `PFRL_ASSERT_NEXT(a_div_start, clock, reset, start, busy_ff && cnt_ff == 7'd64)
   `PFRL_ASSERT_IMPL(a_div_cnt, clock, reset, busy_ff, cnt_ff != 7'd0)
   `PFRL_ASSERT_IMPL(a_div_rem, clock, reset, busy_ff, rem_ff < {1'b0, dvs_ff})
endmodule

// ===== verif/tb_packet_filter_rate_limiter_unit.sv =====
// Testbench for packet_filter_rate_limiter_unit: directed table plus random traffic,
// checked field by field against a behavioral predictor of the filter and limiter.
// Depends on pfrl_pkg and pfrl_if.
module tb_packet_filter_rate_limiter_unit;
   import pfrl_pkg::*;

   typedef struct {
      req_type item;
      logic    known;
      rsp_type golden;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   pfrl_req_if req_bus ();
   pfrl_rsp_if rsp_bus ();
   pfrl_csr_if csr_bus ();

   packet_filter_rate_limiter_unit dut (
      .clock(clock), .reset(reset), .req(req_bus.sink), .rsp(rsp_bus.source),
      .csr(csr_bus.sink)
   );

   // predictor state
   logic [31:0] token_period_q;
   logic [15:0] bucket_size_q;
   logic [31:0] deny_addr [64];
   logic        deny_on [64];
   logic [15:0] rule_port [64];
   logic [7:0]  rule_proto [64];
   logic        rule_allow [64];
   logic        rule_on [64];
   logic [31:0] bkt_src [64];
   logic [15:0] bkt_tokens [64];
   logic [63:0] bkt_time [64];
   logic        bkt_on [64];
   logic [63:0] passed_q, dropped_q;

   rsp_type verdict_queue [$];
   int errors = 0, sent = 0, got = 0;
   int send_idle = 0, recv_idle = 0;
   logic recv_hold = 1'b0;

   function automatic logic addr_denied(logic [31:0] a);
      for (int i = 0; i < 64; i++)
         if (deny_on[i] && deny_addr[i] == a) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic bucket_take(logic [31:0] src, logic [63:0] now,
                                        output logic [15:0] left);
      int free_slot;
      logic [63:0] div, earned, tok;
      free_slot = -1;
      for (int i = 0; i < 64; i++) begin
         if (bkt_on[i]) begin
            if (bkt_src[i] == src) begin
               div = (token_period_q == 0) ? 64'd1 : {32'd0, token_period_q};
               earned = (now - bkt_time[i]) / div;
               if (earned >= 64'd65536) tok = {48'd0, bucket_size_q};
               else tok = {48'd0, bkt_tokens[i]} + earned;
               if (tok > {48'd0, bucket_size_q}) tok = {48'd0, bucket_size_q};
               if (earned > 0) bkt_time[i] = now;
               if (tok > 0) begin
                  tok = tok - 1;
                  bkt_tokens[i] = tok[15:0];
                  left = tok[15:0];
                  return 1'b1;
               end
               bkt_tokens[i] = 16'd0;
               left = 16'd0;
               return 1'b0;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      left = 16'd0;
      if (free_slot < 0) return 1'b1;
      bkt_on[free_slot] = 1'b1;
      bkt_src[free_slot] = src;
      bkt_tokens[free_slot] = (bucket_size_q != 0) ? bucket_size_q - 16'd1 : 16'd0;
      bkt_time[free_slot] = now;
      left = bkt_tokens[free_slot];
      return 1'b1;
   endfunction

   function automatic rsp_type filter_verdict(req_type r);
      rsp_type o;
      logic drop;
      logic [2:0] cause;
      logic [15:0] left, used_port;
      logic [16:0] need;
      drop = 1'b0; cause = CAUSE_OK; left = 16'd0; used_port = 16'd0;
      if (r.action != ACT_PACKET) begin
         if (r.action == ACT_DENY) begin
            deny_addr[r.slot] = r.src_ip;
            deny_on[r.slot] = r.enable;
         end else if (r.action == ACT_RULE) begin
            rule_port[r.slot] = r.dest_port;
            rule_proto[r.slot] = r.protocol;
            rule_allow[r.slot] = r.permit;
            rule_on[r.slot] = r.enable;
         end
         o.verdict = 1'b0; o.cause = CAUSE_WRITE; o.tokens_left = 16'd0;
         o.pass_total = passed_q; o.drop_total = dropped_q;
         return o;
      end
      if (r.frame_length < 14) begin
         drop = 1'b1; cause = CAUSE_TRUNC;
      end else if (r.ethertype != ETHERTYPE_IPV4) begin
         cause = CAUSE_NONIP;
      end else if (r.frame_length < 34) begin
         drop = 1'b1; cause = CAUSE_TRUNC;
      end else if (addr_denied(r.src_ip) || addr_denied(r.dst_ip)) begin
         drop = 1'b1; cause = CAUSE_DENY;
      end else begin
         if (r.protocol == PROTO_TCP || r.protocol == PROTO_UDP) begin
            need = 17'd14 + 17'(r.header_words) * 17'd4 +
                   ((r.protocol == PROTO_TCP) ? 17'd20 : 17'd8);
            if ({1'b0, r.frame_length} < need) begin
               drop = 1'b1; cause = CAUSE_TRUNC;
            end else begin
               used_port = r.dest_port;
            end
         end
         if (!drop && used_port != 0) begin
            for (int i = 0; i < 64; i++) begin
               if (rule_on[i] && rule_port[i] == used_port) begin
                  if ((rule_proto[i] == 0 || rule_proto[i] == r.protocol) &&
                      !rule_allow[i]) begin
                     drop = 1'b1; cause = CAUSE_PORT;
                  end
                  break;
               end
            end
         end
         if (!drop && !bucket_take(r.src_ip, r.now_ns, left)) begin
            drop = 1'b1; cause = CAUSE_RATE;
         end
      end
      if (drop) dropped_q++;
      else passed_q++;
      o.verdict = drop; o.cause = cause; o.tokens_left = left;
      o.pass_total = passed_q; o.drop_total = dropped_q;
      return o;
   endfunction

   // known golden results for directed rows
   rsp_type golden_queue [$];
   logic    golden_known [$];

   task automatic send_item(req_type r, logic known, rsp_type golden);
      rsp_type p;
      @(negedge clock);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      p = filter_verdict(r);
      verdict_queue.push_back(p);
      golden_known.push_back(known);
      golden_queue.push_back(golden);
      sent++;
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] val);
      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data.index <= idx;
      csr_bus.data.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_TOKEN_PERIOD) token_period_q = val;
      else bucket_size_q = val[15:0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: samples at rising edge, ready changes at falling edge
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !recv_hold && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got++;
         if (verdict_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, rsp_bus.data);
         end else begin
            exp_r = verdict_queue.pop_front();
            if (golden_known.pop_front()) begin
               if (golden_queue[0] !== exp_r) begin
                  errors++;
                  $display("%0t: table row mismatch exp %p pred %p", $time,
                           golden_queue[0], exp_r);
               end
            end
            void'(golden_queue.pop_front());
            if (rsp_bus.data.verdict !== exp_r.verdict)
               begin errors++; $display("%0t: verdict exp %0d got %0d", $time,
                     exp_r.verdict, rsp_bus.data.verdict); end
            if (rsp_bus.data.cause !== exp_r.cause)
               begin errors++; $display("%0t: cause exp %0d got %0d", $time,
                     exp_r.cause, rsp_bus.data.cause); end
            if (rsp_bus.data.tokens_left !== exp_r.tokens_left)
               begin errors++; $display("%0t: tokens_left exp %0d got %0d", $time,
                     exp_r.tokens_left, rsp_bus.data.tokens_left); end
            if (rsp_bus.data.pass_total !== exp_r.pass_total)
               begin errors++; $display("%0t: pass_total exp %0d got %0d", $time,
                     exp_r.pass_total, rsp_bus.data.pass_total); end
            if (rsp_bus.data.drop_total !== exp_r.drop_total)
               begin errors++; $display("%0t: drop_total exp %0d got %0d", $time,
                     exp_r.drop_total, rsp_bus.data.drop_total); end
         end
      end
   end

   function automatic req_type blank_item();
      req_type r;
      r = '0;
      r.action = ACT_PACKET;
      r.frame_length = 16'd1500;
      r.ethertype = ETHERTYPE_IPV4;
      r.header_words = 4'd5;
      r.protocol = PROTO_UDP;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int pick;
      logic [223:0] raw;
      r = blank_item();
      pick = $urandom_range(99);
      r.src_ip = 32'h0a000000 | $urandom_range(80);
      r.dst_ip = 32'hc0a80000 | $urandom_range(15);
      r.dest_port = 16'($urandom_range(20));
      r.protocol = ($urandom_range(1)) ? PROTO_TCP : PROTO_UDP;
      r.header_words = 4'($urandom_range(5, 15));
      r.now_ns = {32'd0, 32'($urandom_range(0, 400))} * 64'd1000 + 64'(sent) * 64'd500;
      r.frame_length = 16'($urandom_range(54, 1500));
      r.slot = 6'($urandom);
      r.enable = 1'($urandom);
      r.permit = 1'($urandom);
      if (pick < 8) begin
         r.action = ACT_DENY;
         r.src_ip = ($urandom_range(1)) ? (32'h0a000000 | $urandom_range(80))
                                        : (32'hc0a80000 | $urandom_range(15));
      end else if (pick < 16) begin
         r.action = ACT_RULE;
         r.protocol = ($urandom_range(2) == 0) ? 8'd0 :
                      (($urandom_range(1) != 0) ? PROTO_TCP : PROTO_UDP);
      end else if (pick < 18) begin
         r.action = ACT_NOP;
      end else if (pick < 28) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         r = raw[$bits(req_type)-1:0];
         r.action = ACT_PACKET;
         if ($urandom_range(1)) r.ethertype = ETHERTYPE_IPV4;
      end else if (pick < 34) begin
         r.frame_length = 16'($urandom_range(0, 80));
      end
      return r;
   endfunction

   stim_row_type directed_rows [$];

   function automatic void add_row(req_type r, logic known, rsp_type g);
      stim_row_type s;
      s.item = r; s.known = known; s.golden = g;
      directed_rows.push_back(s);
   endfunction

   function automatic rsp_type gold(logic v, logic [2:0] c, logic [15:0] t,
                                   logic [63:0] p, logic [63:0] d);
      rsp_type o;
      o.verdict = v; o.cause = c; o.tokens_left = t; o.pass_total = p; o.drop_total = d;
      return o;
   endfunction

   function automatic void build_table();
      req_type r;
      r = blank_item(); r.frame_length = 16'd0;
      add_row(r, 1, gold(1, CAUSE_TRUNC, 0, 0, 1));
      r = blank_item(); r.ethertype = 16'hffff; r.frame_length = 16'hffff;
      add_row(r, 1, gold(0, CAUSE_NONIP, 0, 1, 1));
      r = blank_item(); r.frame_length = 16'd33;
      add_row(r, 1, gold(1, CAUSE_TRUNC, 0, 1, 2));
      r = blank_item(); r.src_ip = 32'hffffffff; r.dst_ip = 32'hffffffff;
      r.now_ns = '1; r.header_words = 4'd15; r.frame_length = 16'd81;
      add_row(r, 1, gold(1, CAUSE_TRUNC, 0, 1, 3));
      r = blank_item(); r.src_ip = 32'h01020304; r.dest_port = 16'hffff;
      add_row(r, 1, gold(0, CAUSE_OK, 16'd4999, 2, 3));
      r = blank_item(); r.action = ACT_DENY; r.slot = 6'd63; r.enable = 1;
      r.src_ip = 32'h05060708;
      add_row(r, 1, gold(0, CAUSE_WRITE, 0, 2, 3));
      r = blank_item(); r.dst_ip = 32'h05060708;
      add_row(r, 1, gold(1, CAUSE_DENY, 0, 2, 4));
      r = blank_item(); r.action = ACT_RULE; r.slot = 6'd0; r.enable = 1;
      r.dest_port = 16'd80; r.protocol = 8'd0; r.permit = 0;
      add_row(r, 1, gold(0, CAUSE_WRITE, 0, 2, 4));
      r = blank_item(); r.protocol = PROTO_TCP; r.dest_port = 16'd80;
      add_row(r, 1, gold(1, CAUSE_PORT, 0, 2, 5));
      r = blank_item(); r.action = ACT_RULE; r.slot = 6'd1; r.enable = 1;
      r.dest_port = 16'd81; r.protocol = PROTO_TCP; r.permit = 0;
      add_row(r, 1, gold(0, CAUSE_WRITE, 0, 2, 5));
      r = blank_item(); r.protocol = PROTO_UDP; r.dest_port = 16'd81; r.src_ip = 32'h99;
      add_row(r, 1, gold(0, CAUSE_OK, 16'd4999, 3, 5));
      r = blank_item(); r.protocol = 8'd1; r.dest_port = 16'd80; r.src_ip = 32'h99;
      r.now_ns = 64'd5_000_000;
      add_row(r, 0, '0);
      r = blank_item(); r.action = ACT_NOP;
      add_row(r, 0, '0);
      r = blank_item(); r.src_ip = 32'h99; r.now_ns = 64'd2;
      add_row(r, 0, '0);
      r = blank_item(); r.action = ACT_DENY; r.slot = 6'd63; r.enable = 0;
      r.src_ip = 32'h05060708;
      add_row(r, 0, '0);
   endfunction

   task automatic random_burst(int count, int s_idle, int r_idle);
      send_idle = s_idle; recv_idle = r_idle;
      repeat (count) send_item(random_item(), 1'b0, '0);
   endtask

   initial begin
      int used_rows;
      req_type r;
      req_bus.valid = 1'b0; req_bus.data = '0;
      csr_bus.valid = 1'b0; csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      token_period_q = 32'd1000000; bucket_size_q = 16'd5000;
      passed_q = '0; dropped_q = '0;
      for (int i = 0; i < 64; i++) begin
         deny_addr[i] = '0; deny_on[i] = 0; rule_port[i] = '0; rule_proto[i] = '0;
         rule_allow[i] = 0; rule_on[i] = 0; bkt_src[i] = '0; bkt_tokens[i] = '0;
         bkt_time[i] = '0; bkt_on[i] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      build_table();
      used_rows = directed_rows.size();
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].golden);

      // rapid drain of a small bucket, then refill with a short token period
      write_reg(CSR_BUCKET_SIZE, 32'd3);
      write_reg(CSR_TOKEN_PERIOD, 32'd1);
      for (int i = 0; i < 8; i++) begin
         r = blank_item(); r.src_ip = 32'h77; r.now_ns = 64'(i / 3);
         send_item(r, 1'b0, '0);
      end
      random_burst(250, 23, 69);

      write_reg(CSR_TOKEN_PERIOD, 32'hffffffff);
      write_reg(CSR_BUCKET_SIZE, 32'd65535);
      random_burst(150, 69, 23);

      // long receiver stall while the sender keeps offering items
      recv_hold = 1'b1;
      fork
         begin repeat (400) @(negedge clock); recv_hold = 1'b0; end
         random_burst(10, 0, 0);
      join
      while (verdict_queue.size() != 0) @(negedge clock);

      write_reg(CSR_BUCKET_SIZE, 32'd0);
      write_reg(CSR_TOKEN_PERIOD, 32'd0);
      random_burst(80, 0, 0);
      write_reg(CSR_BUCKET_SIZE, 32'd1);
      write_reg(CSR_TOKEN_PERIOD, 32'd500);
      random_burst(150, 23, 69);
      write_reg(CSR_BUCKET_SIZE, 32'd4);
      write_reg(CSR_TOKEN_PERIOD, 32'd1000);
      random_burst(170, 0, 0);

      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("Sent %0d items (%0d table rows), %0d results checked, %0d passed, %0d dropped.",
               sent, used_rows, got, passed_q, dropped_q);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout waiting for results");
      $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== packet_filter_rate_limiter_unit.f =====
+incdir+sv
sv/pfrl_pkg.sv
sv/pfrl_if.sv
sv/pfrl_div.sv
sv/packet_filter_rate_limiter_unit.sv
verif/tb_packet_filter_rate_limiter_unit.sv
